### design/tccw_pkg.sv
// shared types, constants and helper functions of the text console writer
package tccw_pkg;

  localparam int ROWS      = 25;
  localparam int COLS      = 80;
  localparam int TAB_WIDTH = 8;

  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int LINE_W = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS + 1);
  localparam int RCNT_W = $clog2(ROWS + 1);
  localparam int TCNT_W = $clog2(TAB_WIDTH + 1);

  localparam int CMD_W  = 3;
  localparam int CHAR_W = 8;
  localparam int TCOL_W = 7;
  localparam int TROW_W = 5;
  localparam int SCNT_W = 32;
  localparam int CELL_W = 16;
  localparam int OFF_W  = 11;
  localparam int CLR_W  = 4;
  localparam int CFGI_W = 2;
  localparam int CFGD_W = 4;

  localparam int PS_W   = ((LINE_W > TROW_W) ? LINE_W : TROW_W) + 1;
  localparam int RCMP_W = TROW_W + 2;
  localparam int CCMP_W = TCOL_W + 2;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0700;
  localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

  localparam logic [CLR_W-1:0] FG_RESET = 4'h7;
  localparam logic [CLR_W-1:0] BG_RESET = 4'h0;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT  = 3'd0,
    CMD_GOTO = 3'd1,
    CMD_CLS  = 3'd2,
    CMD_EOL  = 3'd3,
    CMD_EOS  = 3'd4,
    CMD_READ = 3'd5
  } cmd_e;

  typedef enum logic [CFGI_W-1:0] {
    CFG_FG  = 2'd0,
    CFG_BG  = 2'd1,
    CFG_RAW = 2'd2,
    CFG_CEN = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUT,
    OP_SCROLL,
    OP_CLEAR,
    OP_READ
  } op_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] char_code;
    logic [TCOL_W-1:0] target_col;
    logic [TROW_W-1:0] target_row;
  } in_item_t;

  typedef struct packed {
    logic [TCOL_W-1:0] cursor_col;
    logic [TROW_W-1:0] cursor_row;
    logic [SCNT_W-1:0] scroll_count;
    logic [CELL_W-1:0] cell_data;
    logic [OFF_W-1:0]  cursor_offset;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic wrap;
    logic walk_step;
    logic scroll_done;
    logic glyph;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e  op_dec;
    logic in_put;
    logic wrap_pending;
    logic at_bottom;
    logic walk_last;
    logic glyph_last;
  } dp_status_t;

  function automatic logic [LINE_W-1:0] phys_row(logic [LINE_W-1:0] top,
                                                 logic [TROW_W-1:0] row);
    logic [PS_W-1:0] s;
    s = PS_W'(top) + PS_W'(row);
    if (s >= PS_W'(ROWS)) begin
      s = s - PS_W'(ROWS);
    end
    return LINE_W'(s);
  endfunction

  function automatic logic [ADDR_W-1:0] row_base(logic [LINE_W-1:0] prow);
    return ADDR_W'(prow) * ADDR_W'(COLS);
  endfunction

  function automatic logic [ADDR_W-1:0] phys_addr(logic [LINE_W-1:0] top,
                                                  logic [TROW_W-1:0] row,
                                                  logic [COL_W-1:0]  col);
    return row_base(phys_row(top, row)) + ADDR_W'(col);
  endfunction

  // spaces up to the next tab stop, one entry per column
  function automatic logic [TCNT_W-1:0] tab_pad(logic [COL_W-1:0] col);
    logic [TCNT_W-1:0] r;
    r = '0;
    for (int i = 0; i <= COLS; i++) begin
      if (col == COL_W'(i)) begin
        r = TCNT_W'(TAB_WIDTH - (i % TAB_WIDTH));
      end
    end
    return r;
  endfunction

endpackage

### design/tccw_ram.sv
// generic single-port ram with registered read
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/tccw_dp.sv
// datapath: cursor, scroll ring, cell walker, config registers, result register
module tccw_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tccw_pkg::in_item_t         in_data_i,
  input  logic                       cfg_valid_i,
  input  logic [tccw_pkg::CFGI_W-1:0] cfg_index_i,
  input  logic [tccw_pkg::CFGD_W-1:0] cfg_data_i,
  output logic                       cfg_ready_o,
  input  tccw_pkg::ctrl_cmd_t        ctrl_i,
  output tccw_pkg::dp_status_t       status_o,
  output tccw_pkg::out_item_t        out_data_o,
  output logic                       ram_en_o,
  output logic                       ram_we_o,
  output logic [tccw_pkg::ADDR_W-1:0] ram_addr_o,
  output logic [tccw_pkg::CELL_W-1:0] ram_wdata_o,
  input  logic [tccw_pkg::CELL_W-1:0] ram_rdata_i
);
  import tccw_pkg::*;

  logic [COL_W-1:0]  col_q, col_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic [LINE_W-1:0] top_q, top_d;
  logic [SCNT_W-1:0] scroll_q, scroll_d;
  logic [OFF_W-1:0]  shown_q, shown_d;
  logic [CLR_W-1:0]  fg_q, fg_d, bg_q, bg_d;
  logic              raw_q, raw_d, cen_q, cen_d;

  logic [LINE_W-1:0] w_prow_q, w_prow_d;
  logic [ADDR_W-1:0] w_base_q, w_base_d;
  logic [COL_W-1:0]  w_col_q, w_col_d;
  logic [RCNT_W-1:0] w_rows_q, w_rows_d;

  in_item_t          item_q, item_d;
  op_e               op_q, op_d;
  logic              read_ok_q, read_ok_d;
  logic [CHAR_W-1:0] gchar_q, gchar_d;
  logic [TCNT_W-1:0] gcnt_q, gcnt_d;
  out_item_t         out_q, out_d;

  op_e               op_dec;
  logic              wrap_pending, at_bottom, tgt_ok, is_read;
  logic [LINE_W-1:0] cur_prow, next_prow;
  logic [OFF_W-1:0]  cur_off;
  logic [ADDR_W-1:0] glyph_addr, read_addr;

  assign wrap_pending = (col_q == COL_W'(COLS));
  assign at_bottom    = (line_q == LINE_W'(ROWS - 1));
  assign tgt_ok       = (RCMP_W'(item_q.target_row) < RCMP_W'(ROWS)) &&
                        (CCMP_W'(item_q.target_col) < CCMP_W'(COLS));
  assign is_read      = (item_q.cmd == CMD_READ);
  assign cur_prow     = phys_row(top_q, TROW_W'(line_q));
  assign next_prow    = (cur_prow == LINE_W'(ROWS - 1)) ? '0 : cur_prow + 1'b1;
  assign cur_off      = OFF_W'(line_q) * OFF_W'(COLS) + OFF_W'(col_q);
  assign glyph_addr   = phys_addr(top_q, TROW_W'(line_q), col_q);
  assign read_addr    = phys_addr(top_q, item_q.target_row, COL_W'(item_q.target_col));

  always_comb begin
    col_d     = col_q;
    line_d    = line_q;
    top_d     = top_q;
    scroll_d  = scroll_q;
    shown_d   = shown_q;
    fg_d      = fg_q;
    bg_d      = bg_q;
    raw_d     = raw_q;
    cen_d     = cen_q;
    w_prow_d  = w_prow_q;
    w_base_d  = w_base_q;
    w_col_d   = w_col_q;
    w_rows_d  = w_rows_q;
    item_d    = item_q;
    op_d      = op_q;
    read_ok_d = read_ok_q;
    gchar_d   = gchar_q;
    gcnt_d    = gcnt_q;
    out_d     = out_q;
    op_dec    = OP_NONE;

    if (ctrl_i.load) begin
      item_d = in_data_i;
    end

    // command decode, effects applied on exec
    unique case (item_q.cmd)
      CMD_PUT: begin
        if (raw_q) begin
          op_dec = OP_PUT;
          if (ctrl_i.exec) begin
            gchar_d = item_q.char_code;
            gcnt_d  = TCNT_W'(1);
          end
        end else begin
          case (item_q.char_code)
            CH_TAB: begin
              op_dec = OP_PUT;
              if (ctrl_i.exec) begin
                gchar_d = CH_SPACE;
                gcnt_d  = tab_pad(col_q);
              end
            end
            CH_CR: begin
              if (ctrl_i.exec) begin
                col_d = '0;
              end
            end
            CH_LF: begin
              if (at_bottom) begin
                op_dec = OP_SCROLL;
                if (ctrl_i.exec) begin
                  w_prow_d = top_q;
                  w_base_d = row_base(top_q);
                  w_col_d  = '0;
                  w_rows_d = RCNT_W'(1);
                end
              end else if (ctrl_i.exec) begin
                line_d = line_q + 1'b1;
              end
            end
            CH_BS: begin
              if (ctrl_i.exec) begin
                if (col_q != '0) begin
                  col_d = col_q - 1'b1;
                end else if (line_q != '0) begin
                  line_d = line_q - 1'b1;
                  col_d  = COL_W'(COLS - 1);
                end
              end
            end
            default: begin
              op_dec = OP_PUT;
              if (ctrl_i.exec) begin
                gchar_d = item_q.char_code;
                gcnt_d  = TCNT_W'(1);
              end
            end
          endcase
        end
      end
      CMD_GOTO: begin
        if (ctrl_i.exec && tgt_ok) begin
          col_d  = COL_W'(item_q.target_col);
          line_d = LINE_W'(item_q.target_row);
        end
      end
      CMD_CLS: begin
        op_dec = OP_CLEAR;
        if (ctrl_i.exec) begin
          col_d    = '0;
          line_d   = '0;
          w_prow_d = '0;
          w_base_d = '0;
          w_col_d  = '0;
          w_rows_d = RCNT_W'(ROWS);
        end
      end
      CMD_EOL: begin
        if (!wrap_pending) begin
          op_dec = OP_CLEAR;
          if (ctrl_i.exec) begin
            w_prow_d = cur_prow;
            w_base_d = row_base(cur_prow);
            w_col_d  = col_q;
            w_rows_d = RCNT_W'(1);
          end
        end
      end
      CMD_EOS: begin
        if (!wrap_pending) begin
          op_dec = OP_CLEAR;
          if (ctrl_i.exec) begin
            w_prow_d = cur_prow;
            w_base_d = row_base(cur_prow);
            w_col_d  = col_q;
            w_rows_d = RCNT_W'(ROWS) - RCNT_W'(line_q);
          end
        end else if (!at_bottom) begin
          op_dec = OP_CLEAR;
          if (ctrl_i.exec) begin
            w_prow_d = next_prow;
            w_base_d = row_base(next_prow);
            w_col_d  = '0;
            w_rows_d = RCNT_W'(ROWS - 1) - RCNT_W'(line_q);
          end
        end
      end
      CMD_READ: begin
        op_dec = OP_READ;
      end
      default: begin
        op_dec = OP_NONE;
      end
    endcase

    if (ctrl_i.exec) begin
      op_d      = op_dec;
      read_ok_d = is_read && tgt_ok;
    end

    // wrap pending before a glyph: new line, scroll set up at the bottom row
    if (ctrl_i.wrap) begin
      col_d = '0;
      if (at_bottom) begin
        w_prow_d = top_q;
        w_base_d = row_base(top_q);
        w_col_d  = '0;
        w_rows_d = RCNT_W'(1);
      end else begin
        line_d = line_q + 1'b1;
      end
    end

    if (ctrl_i.walk_step) begin
      if (w_col_q == COL_W'(COLS - 1)) begin
        w_col_d  = '0;
        w_rows_d = w_rows_q - 1'b1;
        if (w_prow_q == LINE_W'(ROWS - 1)) begin
          w_prow_d = '0;
          w_base_d = '0;
        end else begin
          w_prow_d = w_prow_q + 1'b1;
          w_base_d = w_base_q + ADDR_W'(COLS);
        end
      end else begin
        w_col_d = w_col_q + 1'b1;
      end
    end

    if (ctrl_i.scroll_done) begin
      top_d    = (top_q == LINE_W'(ROWS - 1)) ? '0 : top_q + 1'b1;
      scroll_d = scroll_q + 1'b1;
    end

    if (ctrl_i.glyph) begin
      col_d  = col_q + 1'b1;
      gcnt_d = gcnt_q - 1'b1;
    end

    if (ctrl_i.finish) begin
      if (cen_q) begin
        shown_d = cur_off;
      end
      out_d.cursor_col    = TCOL_W'(col_q);
      out_d.cursor_row    = TROW_W'(line_q);
      out_d.scroll_count  = scroll_q;
      out_d.cell_data     = read_ok_q ? ram_rdata_i : '0;
      out_d.cursor_offset = cen_q ? cur_off : shown_q;
    end

    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FG:  fg_d  = cfg_data_i[CLR_W-1:0];
        CFG_BG:  bg_d  = cfg_data_i[CLR_W-1:0];
        CFG_RAW: raw_d = cfg_data_i[0];
        CFG_CEN: begin
          cen_d = cfg_data_i[0];
          if (cfg_data_i[0]) begin
            shown_d = cur_off;
          end
        end
      endcase
    end
  end

  always_comb begin
    ram_en_o    = ctrl_i.walk_step || ctrl_i.glyph || (ctrl_i.exec && is_read);
    ram_we_o    = ctrl_i.walk_step || ctrl_i.glyph;
    ram_wdata_o = ctrl_i.walk_step ? BLANK_CELL : {bg_q, fg_q, gchar_q};
    if (ctrl_i.walk_step) begin
      ram_addr_o = w_base_q + ADDR_W'(w_col_q);
    end else if (ctrl_i.glyph) begin
      ram_addr_o = glyph_addr;
    end else begin
      ram_addr_o = read_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      line_q   <= '0;
      top_q    <= '0;
      scroll_q <= '0;
      shown_q  <= '0;
      fg_q     <= FG_RESET;
      bg_q     <= BG_RESET;
      raw_q    <= 1'b0;
      cen_q    <= 1'b1;
      w_prow_q <= '0;
      w_base_q <= '0;
      w_col_q  <= '0;
      w_rows_q <= RCNT_W'(ROWS);
    end else begin
      col_q    <= col_d;
      line_q   <= line_d;
      top_q    <= top_d;
      scroll_q <= scroll_d;
      shown_q  <= shown_d;
      fg_q     <= fg_d;
      bg_q     <= bg_d;
      raw_q    <= raw_d;
      cen_q    <= cen_d;
      w_prow_q <= w_prow_d;
      w_base_q <= w_base_d;
      w_col_q  <= w_col_d;
      w_rows_q <= w_rows_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    op_q      <= op_d;
    read_ok_q <= read_ok_d;
    gchar_q   <= gchar_d;
    gcnt_q    <= gcnt_d;
    out_q     <= out_d;
  end

  assign status_o.op_dec       = op_dec;
  assign status_o.in_put       = (op_q == OP_PUT);
  assign status_o.wrap_pending = wrap_pending;
  assign status_o.at_bottom    = at_bottom;
  assign status_o.walk_last    = (w_col_q == COL_W'(COLS - 1)) && (w_rows_q == RCNT_W'(1));
  assign status_o.glyph_last   = (gcnt_q == TCNT_W'(1));

  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

### design/tccw_ctrl.sv
// controller: sequences reset sweep, command execution, walks and result handoff
module tccw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  tccw_pkg::dp_status_t status_i,
  output tccw_pkg::ctrl_cmd_t  ctrl_o
);
  import tccw_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_GLYPH,
    S_SCROLL,
    S_CLEAR,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   in_stall_q;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_INIT: begin
        ctrl_o.walk_step = 1'b1;
        if (status_i.walk_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        ctrl_o.exec = 1'b1;
        unique case (status_i.op_dec)
          OP_PUT:    state_d = S_GLYPH;
          OP_SCROLL: state_d = S_SCROLL;
          OP_CLEAR:  state_d = S_CLEAR;
          default:   state_d = S_DONE;
        endcase
      end
      S_GLYPH: begin
        if (status_i.wrap_pending) begin
          ctrl_o.wrap = 1'b1;
          if (status_i.at_bottom) begin
            state_d = S_SCROLL;
          end
        end else begin
          ctrl_o.glyph = 1'b1;
          if (status_i.glyph_last) begin
            state_d = S_DONE;
          end
        end
      end
      S_SCROLL: begin
        ctrl_o.walk_step = 1'b1;
        if (status_i.walk_last) begin
          ctrl_o.scroll_done = 1'b1;
          state_d = status_i.in_put ? S_GLYPH : S_DONE;
        end
      end
      S_CLEAR: begin
        ctrl_o.walk_step = 1'b1;
        if (status_i.walk_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          ctrl_o.finish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      in_stall_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_stall_q  <= (state_d != S_IDLE);
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = in_stall_q;
  assign out_valid_o = out_valid_q;

endmodule

### design/text_console_char_writer_core.sv
// top level of the text console character writer
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  in_data_i   (in_item_t)
//   out      output     out_valid_o/out_stall_i out_data_o (out_item_t)
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one command at a time: a plain put runs through the idle, exec, glyph and done states; a goto,
// cr, backspace, read or an lf above the last row runs through idle, exec and done
// a tab writes one cell a cycle for each pad space, except where a wrap or a scroll comes between
// a scroll blanks one row; clears walk one cell a cycle through the single ram port
// after reset the ram is swept to blank with in_stall_o high
// a finished transaction waits in the output register while out_stall_i is high
module text_console_char_writer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tccw_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tccw_pkg::out_item_t         out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tccw_pkg::CFGI_W-1:0] cfg_index_i,
  input  logic [tccw_pkg::CFGD_W-1:0] cfg_data_i
);
  import tccw_pkg::*;

  ctrl_cmd_t         ctrl;
  dp_status_t        status;
  logic              ram_en, ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  tccw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  tccw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .out_data_o  (out_data_o),
    .ram_en_o    (ram_en),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  tccw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule
